// ===== hdl/hse_pkg.sv =====
package hse_pkg;

    // Default number of elements the store can hold.
    localparam int CAPACITY_DEF = 512;

    // Width of one element.
    localparam int DATA_W = 32;

    // Elements are kept with the sign bit inverted so that an unsigned compare
    // gives the signed order.
    localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

    // Request commands.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_SORT_INIT,
        S_SIFT_RD,
        S_SIFT_HOLD,
        S_CHILD,
        S_CMP,
        S_NEXT,
        S_SWAP_RD,
        S_SWAP_WR
    } state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_POP_FAIL,
        OP_POP_LOAD,
        OP_SORT_INIT,
        OP_SIFT_RD,
        OP_SIFT_HOLD,
        OP_CHILD,
        OP_CMP,
        OP_NEXT_BUILD,
        OP_NEXT_EXTRACT,
        OP_SWAP_RD,
        OP_SWAP_WR
    } op_t;

    // Status flags returned by the datapath.
    typedef struct packed {
        logic pop_ok;
        logic n_small;
        logic leaf;
        logic sift_stop;
        logic k_zero;
        logic end_one;
    } dp_stat_t;

endpackage

// ===== hdl/hse_datapath.sv =====
module hse_datapath #(
    parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hse_pkg::op_t               op,
    input  logic [hse_pkg::DATA_W-1:0] value,
    input  logic                       last,
    output hse_pkg::dp_stat_t          stat,
    output logic [hse_pkg::DATA_W-1:0] value_out,
    output logic                       last_out,
    output logic [1:0]                 status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Element store: one write port, two registered read ports.
    logic [hse_pkg::DATA_W-1:0] element_store [CAPACITY];

    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              rptr_reg, rptr_next;
    logic                       sorted_reg, sorted_next;
    logic [AW-1:0]              k_reg, k_next;
    logic [AW-1:0]              top_reg, top_next;
    logic [AW-1:0]              bound_reg, bound_next;
    logic [AW-1:0]              end_reg, end_next;
    logic [hse_pkg::DATA_W-1:0] held_reg, held_next;
    logic [hse_pkg::DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic                       pop_last_reg, pop_last_next;
    logic [hse_pkg::DATA_W-1:0] value_out_reg, value_out_next;
    logic                       last_out_reg, last_out_next;
    hse_pkg::status_t           status_reg, status_next;

    logic                       mem_we;
    logic [AW-1:0]              waddr;
    logic [hse_pkg::DATA_W-1:0] wdata;
    logic [AW-1:0]              raddr_a;
    logic [AW-1:0]              raddr_b;

    logic [AW:0]                child;
    logic [AW:0]                child_b;
    logic                       leaf;
    logic                       pick_b;
    logic [hse_pkg::DATA_W-1:0] big_val;
    logic [AW-1:0]              big_idx;
    logic                       sift_stop;
    logic [CW-1:0]              base_cnt;
    logic                       has_room;
    logic [CW-1:0]              count_m1;
    logic [CW-1:0]              rptr_inc;

    // Children of the current sift position and the larger of the two.
    assign child     = {top_reg, 1'b1};
    assign child_b   = child + 1'b1;
    assign leaf      = child > {1'b0, bound_reg};
    assign pick_b    = (child < {1'b0, bound_reg}) && (rd_a_reg < rd_b_reg);
    assign big_val   = pick_b ? rd_b_reg : rd_a_reg;
    assign big_idx   = pick_b ? child_b[AW-1:0] : child[AW-1:0];
    assign sift_stop = !(held_reg < big_val);

    // A push after a finished sort starts a new batch.
    assign base_cnt = sorted_reg ? '0 : count_reg;
    assign has_room = base_cnt < CW'(CAPACITY);
    assign count_m1 = count_reg - 1'b1;
    assign rptr_inc = rptr_reg + 1'b1;

    // Status back to the controller.
    assign stat.pop_ok    = sorted_reg && (rptr_reg < count_reg);
    assign stat.n_small   = count_reg < CW'(2);
    assign stat.leaf      = leaf;
    assign stat.sift_stop = sift_stop;
    assign stat.k_zero    = (k_reg == '0);
    assign stat.end_one   = (end_reg == AW'(1));

    // Operation decode: next values and memory port control.
    always_comb
    begin
        count_next     = count_reg;
        rptr_next      = rptr_reg;
        sorted_next    = sorted_reg;
        k_next         = k_reg;
        top_next       = top_reg;
        bound_next     = bound_reg;
        end_next       = end_reg;
        held_next      = held_reg;
        pop_last_next  = pop_last_reg;
        value_out_next = value_out_reg;
        last_out_next  = last_out_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        waddr          = top_reg;
        wdata          = held_reg;
        raddr_a        = top_reg;
        raddr_b        = child_b[AW-1:0];
        unique case (op)
            hse_pkg::OP_NONE:
            begin
            end
            hse_pkg::OP_PUSH:
            begin
                count_next  = base_cnt;
                sorted_next = 1'b0;
                if (sorted_reg)
                begin
                    rptr_next = '0;
                end
                if (has_room)
                begin
                    mem_we     = 1'b1;
                    waddr      = base_cnt[AW-1:0];
                    wdata      = value ^ hse_pkg::SIGN_FLIP;
                    count_next = base_cnt + 1'b1;
                end
                if (last)
                begin
                    sorted_next = 1'b1;
                    rptr_next   = '0;
                end
                value_out_next = '0;
                last_out_next  = 1'b0;
                status_next    = has_room ? hse_pkg::ST_OK : hse_pkg::ST_FULL;
            end
            hse_pkg::OP_POP:
            begin
                raddr_a       = rptr_reg[AW-1:0];
                rptr_next     = rptr_inc;
                pop_last_next = (rptr_inc == count_reg);
            end
            hse_pkg::OP_POP_FAIL:
            begin
                value_out_next = '0;
                last_out_next  = 1'b0;
                status_next    = hse_pkg::ST_EMPTY;
            end
            hse_pkg::OP_POP_LOAD:
            begin
                value_out_next = rd_a_reg ^ hse_pkg::SIGN_FLIP;
                last_out_next  = pop_last_reg;
                status_next    = hse_pkg::ST_OK;
            end
            hse_pkg::OP_SORT_INIT:
            begin
                k_next     = AW'(count_m1 >> 1);
                top_next   = AW'(count_m1 >> 1);
                bound_next = count_m1[AW-1:0];
                end_next   = count_m1[AW-1:0];
            end
            hse_pkg::OP_SIFT_RD:
            begin
                raddr_a = top_reg;
            end
            hse_pkg::OP_SIFT_HOLD:
            begin
                held_next = rd_a_reg;
            end
            hse_pkg::OP_CHILD:
            begin
                if (leaf)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    raddr_a = child[AW-1:0];
                    raddr_b = child_b[AW-1:0];
                end
            end
            hse_pkg::OP_CMP:
            begin
                mem_we = 1'b1;
                if (!sift_stop)
                begin
                    wdata    = big_val;
                    top_next = big_idx;
                end
            end
            hse_pkg::OP_NEXT_BUILD:
            begin
                if (!stat.k_zero)
                begin
                    k_next   = k_reg - 1'b1;
                    top_next = k_reg - 1'b1;
                end
            end
            hse_pkg::OP_NEXT_EXTRACT:
            begin
                if (!stat.end_one)
                begin
                    end_next = end_reg - 1'b1;
                end
            end
            hse_pkg::OP_SWAP_RD:
            begin
                raddr_a = '0;
                raddr_b = end_reg;
            end
            hse_pkg::OP_SWAP_WR:
            begin
                mem_we     = 1'b1;
                waddr      = end_reg;
                wdata      = rd_a_reg;
                held_next  = rd_b_reg;
                top_next   = '0;
                bound_next = end_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Batch control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rptr_reg   <= '0;
            sorted_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rptr_reg   <= rptr_next;
            sorted_reg <= sorted_next;
        end
    end

    // Sift registers and result payload.
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        top_reg       <= top_next;
        bound_reg     <= bound_next;
        end_reg       <= end_next;
        held_reg      <= held_next;
        pop_last_reg  <= pop_last_next;
        value_out_reg <= value_out_next;
        last_out_reg  <= last_out_next;
        status_reg    <= status_next;
    end

    // Element store write and registered reads.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            element_store[waddr] <= wdata;
        end
        rd_a_reg <= element_store[raddr_a];
        rd_b_reg <= element_store[raddr_b];
    end

    assign value_out = value_out_reg;
    assign last_out  = last_out_reg;
    assign status    = status_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // Reads never run past the loaded elements.
    a_rptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rptr_reg <= count_reg)
        else $error("read pointer past element count");

    // A compare step always works on a parent inside the heap.
    a_cmp_parent: assert property (@(posedge clk) disable iff (!rst_n)
        op == hse_pkg::OP_CMP |-> top_reg < bound_reg)
        else $error("compare step outside heap");

endmodule

// ===== hdl/hse_ctrl.sv =====
module hse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    input  hse_pkg::dp_stat_t stat,
    output hse_pkg::op_t      op
);

    hse_pkg::state_t state_reg, state_next;
    logic            build_reg, build_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            out_load;

    // New requests only in idle, and only when the result register is free or is being read in this cycle.
    assign in_ready = (state_reg == hse_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        build_next = build_reg;
        unique case (state_reg)
            hse_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == hse_pkg::CMD_POP)
                    begin
                        state_next = stat.pop_ok ? hse_pkg::S_POP_RD : hse_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = last ? hse_pkg::S_SORT_INIT : hse_pkg::S_IDLE;
                    end
                end
            end
            hse_pkg::S_POP_RD:
            begin
                state_next = hse_pkg::S_IDLE;
            end
            hse_pkg::S_SORT_INIT:
            begin
                build_next = 1'b1;
                state_next = stat.n_small ? hse_pkg::S_IDLE : hse_pkg::S_SIFT_RD;
            end
            hse_pkg::S_SIFT_RD:
            begin
                state_next = hse_pkg::S_SIFT_HOLD;
            end
            hse_pkg::S_SIFT_HOLD:
            begin
                state_next = hse_pkg::S_CHILD;
            end
            hse_pkg::S_CHILD:
            begin
                state_next = stat.leaf ? hse_pkg::S_NEXT : hse_pkg::S_CMP;
            end
            hse_pkg::S_CMP:
            begin
                state_next = stat.sift_stop ? hse_pkg::S_NEXT : hse_pkg::S_CHILD;
            end
            hse_pkg::S_NEXT:
            begin
                if (build_reg)
                begin
                    if (stat.k_zero)
                    begin
                        build_next = 1'b0;
                        state_next = hse_pkg::S_SWAP_RD;
                    end
                    else
                    begin
                        state_next = hse_pkg::S_SIFT_RD;
                    end
                end
                else
                begin
                    state_next = stat.end_one ? hse_pkg::S_IDLE : hse_pkg::S_SWAP_RD;
                end
            end
            hse_pkg::S_SWAP_RD:
            begin
                state_next = hse_pkg::S_SWAP_WR;
            end
            hse_pkg::S_SWAP_WR:
            begin
                state_next = hse_pkg::S_CHILD;
            end
            default:
            begin
                state_next = hse_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath operation for each state.
    always_comb
    begin
        op       = hse_pkg::OP_NONE;
        out_load = 1'b0;
        unique case (state_reg)
            hse_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == hse_pkg::CMD_PUSH)
                    begin
                        op       = hse_pkg::OP_PUSH;
                        out_load = 1'b1;
                    end
                    else if (stat.pop_ok)
                    begin
                        op = hse_pkg::OP_POP;
                    end
                    else
                    begin
                        op       = hse_pkg::OP_POP_FAIL;
                        out_load = 1'b1;
                    end
                end
            end
            hse_pkg::S_POP_RD:
            begin
                op       = hse_pkg::OP_POP_LOAD;
                out_load = 1'b1;
            end
            hse_pkg::S_SORT_INIT: op = hse_pkg::OP_SORT_INIT;
            hse_pkg::S_SIFT_RD:   op = hse_pkg::OP_SIFT_RD;
            hse_pkg::S_SIFT_HOLD: op = hse_pkg::OP_SIFT_HOLD;
            hse_pkg::S_CHILD:     op = hse_pkg::OP_CHILD;
            hse_pkg::S_CMP:       op = hse_pkg::OP_CMP;
            hse_pkg::S_NEXT:
            begin
                op = build_reg ? hse_pkg::OP_NEXT_BUILD : hse_pkg::OP_NEXT_EXTRACT;
            end
            hse_pkg::S_SWAP_RD:   op = hse_pkg::OP_SWAP_RD;
            hse_pkg::S_SWAP_WR:   op = hse_pkg::OP_SWAP_WR;
            default:
            begin
                op = hse_pkg::OP_NONE;
            end
        endcase
    end

    // Result register occupancy.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hse_pkg::S_IDLE;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A good pop goes to fetch its element on the next cycle.
    a_pop_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == hse_pkg::CMD_POP && stat.pop_ok |=> state_reg == hse_pkg::S_POP_RD)
        else $error("pop did not fetch its element");

    // The result register is free when pop data arrives.
    a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hse_pkg::S_POP_RD |-> !out_valid_reg)
        else $error("pop data would overwrite a pending result");

    // A sort only starts after a push marked last.
    a_sort_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hse_pkg::S_SORT_INIT |->
            $past(accept && cmd == hse_pkg::CMD_PUSH && last))
        else $error("sort started without a last push");

endmodule

// ===== hdl/heap_sort_engine.sv =====
// Heapsort engine. Push requests (cmd 0) load signed 32-bit values into an
// on-chip store of CAPACITY entries; each push returns one result with status
// ok, or full when the store is already full and the value is dropped. A push
// with last set then sorts the batch in place with heapsort, and pop requests
// (cmd 1) return the values in ascending order, with last_out set on the final
// one and status empty when there is nothing left to read. A push and a pop
// that finds nothing left are answered from idle; a pop that returns a value
// also passes through a state for the registered read of the store.
// After a push with last, no request is taken until the sort is done: each
// sift step is one state that reads both children and one that compares and
// writes, bound by the store's one write port and two read ports. The store
// needs no clearing pass after reset.
module heap_sort_engine #(
    parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [hse_pkg::DATA_W-1:0] value,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hse_pkg::DATA_W-1:0] value_out,
    output logic                       last_out,
    output logic [1:0]                 status
);

    hse_pkg::op_t      op;
    hse_pkg::dp_stat_t stat;

    // Sequencer for requests and the sort passes.
    hse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    // Element store, counters, sift registers and result register.
    hse_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .value     (value),
        .last      (last),
        .stat      (stat),
        .value_out (value_out),
        .last_out  (last_out),
        .status    (status)
    );

endmodule
